>>> sv/ppbr_pkg.sv
// Shared constants and codes for the packed pixel to BGRA rotator.
// No dependencies; imported by the top level and its checker.
package ppbr_pkg;

  localparam int MAX_DIM       = 127;
  localparam int BUFFER_PIXELS = 2048;

  localparam int MODEL_W  = 2;
  localparam int DIM_W    = 7;
  localparam int HDIM_W   = 8;
  localparam int PIX_W    = 11;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 40;
  localparam int ADDR_W   = 4;
  localparam int APB_DW   = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SENSOR_MODEL = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // sensor orientations; the unused code behaves as rotated
  localparam logic [MODEL_W-1:0] MODEL_ROTATED = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_DIRECT  = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_FLIPPED = 2'd2;

  // input opcodes and result kinds
  localparam logic OP_HEADER   = 1'b0;
  localparam logic OP_PIXEL    = 1'b1;
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // header modes
  localparam logic [HDIM_W-1:0] MODE_AREA = 8'd1;
  localparam logic [HDIM_W-1:0] MODE_LINE = 8'd3;

endpackage

>>> sv/packed_pixel_to_bgra_rotator_top.sv
// Path from input request to out_tvalid: input register, then result register.
// Throughput: one request per cycle unless a result stalls; one input request can wait then.
// Colour split and slot mapping sit between the two registers; slot uses one 11x11 multiply.
// Reset (rst_n low, synchronous): pipeline empty, counters zero, no frame accepted,
// sensor_model 0, frame_width 1, frame_height 1.
// Depends on ppbr_pkg.
module packed_pixel_to_bgra_rotator_top
  import ppbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // header_mode[7:0], dim_first[15:8], dim_second[23:16],
  // byte_first[31:24], byte_second[39:32]
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tuser,   // opcode
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // header_match[0], pixel_index[11:1], blue_out[19:12], green_out[27:20],
  // red_out[35:28], zero[39:36]
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tuser,  // result_kind
  output logic              out_tlast   // last_pixel
);

  localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_PIXELS);
  localparam logic [HDIM_W-1:0] DIM_LIMIT = HDIM_W'(MAX_DIM);

  // configuration registers
  logic [MODEL_W-1:0] sensor_model_r;
  logic [DIM_W-1:0]   frame_width_r;
  logic [DIM_W-1:0]   frame_height_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_model_r <= MODEL_ROTATED;
      frame_width_r  <= DIM_W'(1);
      frame_height_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_SENSOR_MODEL: sensor_model_r <= cfg_pwdata[MODEL_W-1:0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SENSOR_MODEL: cfg_prdata = APB_DW'(sensor_model_r);
      REG_FRAME_WIDTH:  cfg_prdata = APB_DW'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // input register
  logic              in_valid_r;
  logic              in_op_r;
  logic [IN_DW-1:0]  in_data_r;
  logic              advance;

  // result register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_kind_r;
  logic              out_last_r;

  // frame state
  logic [DIM_W-1:0]  column_count_r, column_count_nxt;
  logic [DIM_W-1:0]  row_count_r, row_count_nxt;
  logic              frame_accepted_r, frame_accepted_nxt;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_data_r <= in_tdata;
    end
  end

  // field split
  logic [HDIM_W-1:0] header_mode, dim_first, dim_second, byte_first, byte_second;
  assign header_mode = in_data_r[7:0];
  assign dim_first   = in_data_r[15:8];
  assign dim_second  = in_data_r[23:16];
  assign byte_first  = in_data_r[31:24];
  assign byte_second = in_data_r[39:32];

  // header check; rotated sensor reports height first
  logic              swap_dims;
  logic [HDIM_W-1:0] hdr_w, hdr_h, cfg_mode;
  logic [15:0]       hdr_area;
  logic              hdr_match;

  assign swap_dims = (sensor_model_r != MODEL_DIRECT) && (sensor_model_r != MODEL_FLIPPED);
  assign hdr_w     = swap_dims ? dim_second : dim_first;
  assign hdr_h     = swap_dims ? dim_first  : dim_second;
  assign cfg_mode  = (frame_height_r == DIM_W'(1)) ? MODE_LINE : MODE_AREA;
  assign hdr_area  = 16'(hdr_w) * 16'(hdr_h);
  assign hdr_match = (header_mode == cfg_mode)
                   && (hdr_w == HDIM_W'(frame_width_r))
                   && (hdr_h == HDIM_W'(frame_height_r))
                   && (hdr_w <= DIM_LIMIT) && (hdr_h <= DIM_LIMIT)
                   && ({1'b0, hdr_area} <= BUF_LIMIT);

  // slot = mul_a * mul_b + mul_c, all modulo 2^11
  logic [PIX_W-1:0]   col_x, row_x, fw_x, fh_x, col_rev, row_rev;
  logic [PIX_W-1:0]   mul_a, mul_b, mul_c, slot;
  logic [2*PIX_W-1:0] mul_p;

  assign col_x   = PIX_W'(column_count_r);
  assign row_x   = PIX_W'(row_count_r);
  assign fw_x    = PIX_W'(frame_width_r);
  assign fh_x    = PIX_W'(frame_height_r);
  assign col_rev = fw_x - PIX_W'(1) - col_x;
  assign row_rev = fh_x - PIX_W'(1) - row_x;

  always_comb begin
    case (sensor_model_r)
      MODEL_DIRECT: begin
        mul_a = col_x;   mul_b = fh_x; mul_c = row_x;
      end
      MODEL_FLIPPED: begin
        mul_a = col_rev; mul_b = fh_x; mul_c = row_rev;
      end
      default: begin
        mul_a = row_x;   mul_b = fw_x; mul_c = col_rev;
      end
    endcase
  end

  assign mul_p = (2*PIX_W)'(mul_a) * (2*PIX_W)'(mul_b);
  assign slot  = mul_p[PIX_W-1:0] + mul_c;

  // colour split
  logic [7:0] red, green, blue;
  assign red   = byte_first & 8'hF8;
  assign green = {byte_first[2:0], byte_second[7:3]};
  assign blue  = {byte_second[4:0], 3'b000};

  // counters: row runs fastest (column-major arrival)
  logic [DIM_W:0] row_inc, col_inc;
  logic           row_wrap, col_wrap;
  logic           is_pixel_out;

  assign row_inc      = {1'b0, row_count_r} + (DIM_W+1)'(1);
  assign col_inc      = {1'b0, column_count_r} + (DIM_W+1)'(1);
  assign row_wrap     = row_inc >= {1'b0, frame_height_r};
  assign col_wrap     = col_inc >= {1'b0, frame_width_r};
  assign is_pixel_out = (in_op_r == OP_PIXEL) && frame_accepted_r;

  always_comb begin
    column_count_nxt   = column_count_r;
    row_count_nxt      = row_count_r;
    frame_accepted_nxt = frame_accepted_r;
    if (advance) begin
      if (in_op_r == OP_HEADER) begin
        column_count_nxt   = '0;
        row_count_nxt      = '0;
        frame_accepted_nxt = hdr_match && (hdr_w != '0) && (hdr_h != '0);
      end else if (frame_accepted_r) begin
        if (row_wrap) begin
          row_count_nxt = '0;
          if (col_wrap) begin
            column_count_nxt   = '0;
            frame_accepted_nxt = 1'b0;
          end else begin
            column_count_nxt = col_inc[DIM_W-1:0];
          end
        end else begin
          row_count_nxt = row_inc[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r   <= '0;
      row_count_r      <= '0;
      frame_accepted_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      column_count_r   <= column_count_nxt;
      row_count_r      <= row_count_nxt;
      frame_accepted_r <= frame_accepted_nxt;
      if (advance) begin
        out_valid_r <= (in_op_r == OP_HEADER) || frame_accepted_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_pixel_out) begin
        out_kind_r <= KIND_PIXEL;
        out_last_r <= row_wrap & col_wrap;
        out_data_r <= {4'b0000, red, green, blue, slot, 1'b1};
      end else begin
        out_kind_r <= KIND_HEADER;
        out_last_r <= 1'b0;
        out_data_r <= {(OUT_DW-1)'(0), hdr_match};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/ppbr_checker.sv
// Port-level checks for packed_pixel_to_bgra_rotator_top, attached by bind.
// Depends on ppbr_pkg.
module ppbr_checker
  import ppbr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  // input side only backs up when the result register is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without a stalled result");

  a_pixel_matched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PIXEL) |-> out_tdata[0])
    else $error("pixel result without header_match");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_HEADER) |-> (out_tdata[OUT_DW-1:1] == '0 && !out_tlast))
    else $error("header result carries pixel fields");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind packed_pixel_to_bgra_rotator_top ppbr_checker u_ppbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
